[design/lgfm_pkg.sv]
// ----------------------------------------------------------------------------
// lgfm_pkg
// Types and constants shared by the label gap fill marker and its channels.
// ----------------------------------------------------------------------------
package lgfm_pkg;

  // Field widths fixed by the stream format
  localparam int unsigned LabelW  = 16;
  localparam int unsigned PosW    = 10;
  localparam int unsigned LimitW  = 8;
  localparam int unsigned LenW    = 8;
  localparam int unsigned CountW  = 9;

  // Gap limit after reset
  localparam logic [LimitW-1:0] GapLimitRst = 8'd4;

  // One input pixel
  typedef struct packed {
    logic signed [LabelW-1:0] label;
    logic [PosW-1:0]          col;
    logic [PosW-1:0]          row;
  } lgfm_pix_t;

  // One result: gap runs ending just before the pixel
  typedef struct packed {
    logic [PosW-1:0] out_row;
    logic [PosW-1:0] out_col;
    logic            h_fill;
    logic [LenW-1:0] h_length;
    logic            v_fill;
    logic [LenW-1:0] v_length;
  } lgfm_res_t;

endpackage

[design/lgfm_pix_if.sv]
// ----------------------------------------------------------------------------
// lgfm_pix_if
// Valid/ready channel carrying one labelled pixel per transaction.
// ----------------------------------------------------------------------------
interface lgfm_pix_if
  import lgfm_pkg::*;
;
  logic      valid;
  logic      ready;
  lgfm_pix_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/lgfm_res_if.sv]
// ----------------------------------------------------------------------------
// lgfm_res_if
// Valid/ready channel carrying one gap result per transaction.
// ----------------------------------------------------------------------------
interface lgfm_res_if
  import lgfm_pkg::*;
;
  logic      valid;
  logic      ready;
  lgfm_res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/label_gap_fill_marker_core.sv]
// ----------------------------------------------------------------------------
// label_gap_fill_marker_core
// Marks short background runs between differing labels along rows and columns.
// ----------------------------------------------------------------------------
// Pipeline: a pixel transaction reads the column-state memory into stage 1,
//   then the compute goes into the output register, which drives result valid.
// Throughput: one pixel per cycle unless res_o stalls; the column-state
//   memory has one read and one write port; per pixel one read, one write-back.
// Reset: clears the row state, pipeline valids and sets the gap limit to 4.
//   Column-state memory is not cleared; an entry is defined once row 0 has
//   passed through that column.
// ----------------------------------------------------------------------------
module label_gap_fill_marker_core
  import lgfm_pkg::*;
#(
  parameter int MAX_COLS   = 1024,
  parameter int LABEL_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [LimitW-1:0] cfg_wdata_i,
  lgfm_pix_if.sink          pix_i,
  lgfm_res_if.source        res_o
);

  // Labels are compared on at most the width of the label field
  localparam int LW = (LABEL_BITS < int'(LabelW)) ? LABEL_BITS : int'(LabelW);
  localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  // Per-axis scan state: countdown and last nonzero label
  typedef struct packed {
    logic [CountW-1:0] cnt;
    logic [LW-1:0]     tag;
  } ent_t;

  typedef struct packed {
    ent_t            ent;
    logic [LenW-1:0] len;
  } axis_t;

  // One axis step: measure the run closed by this pixel, then reload or
  // count down. Length is clipped to the pixel position.
  function automatic axis_t scan_axis(ent_t cur, logic [LW-1:0] pix,
                                      logic [LimitW-1:0] limit,
                                      logic [PosW-1:0] pos);
    axis_t res;
    res.len = '0;
    res.ent = cur;
    if (pix != '0) begin
      if ((cur.cnt != '0) && (pix != cur.tag) && ({1'b0, limit} > cur.cnt)) begin
        res.len = LenW'({1'b0, limit} - cur.cnt);
      end
      // reload with the limit; the countdown below does not run for this pixel
      res.ent.cnt = {1'b0, limit};
      res.ent.tag = pix;
    end else if (cur.cnt != '0) begin
      res.ent.cnt = cur.cnt - 1'b1;
    end
    if ({{(PosW-LenW){1'b0}}, res.len} > pos) begin
      res.len = pos[LenW-1:0];
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [LimitW-1:0] gap_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_limit_q <= GapLimitRst;
    end else if (cfg_we_i) begin
      gap_limit_q <= cfg_wdata_i;
    end
  end

  // --------------------------------------------------------------------------
  // Handshake control
  // --------------------------------------------------------------------------
  logic s1_valid_q;
  logic out_valid_q;
  logic s1_adv;
  logic in_fire;

  // Stage 1 moves on whenever the output register is empty or being drained;
  // this keeps a new pixel flowing in while a finished result waits.
  assign s1_adv      = s1_valid_q && (!out_valid_q || res_o.ready);
  assign pix_i.ready = !s1_valid_q || s1_adv;
  assign in_fire     = pix_i.valid && pix_i.ready;

  // --------------------------------------------------------------------------
  // Column index: column modulo MAX_COLS by restoring subtraction of the
  // shifted depth; steps whose divisor exceeds the column range drop out.
  // --------------------------------------------------------------------------
  logic [PosW-1:0] col_mod;
  logic [AW-1:0]   ci;

  always_comb begin
    col_mod = pix_i.data.col;
    for (int k = PosW - 1; k >= 0; k--) begin
      if ((MAX_COLS << k) < (1 << PosW)) begin
        if (32'(col_mod) >= 32'(MAX_COLS << k)) begin
          col_mod = col_mod - PosW'(MAX_COLS << k);
        end
      end
    end
  end

  assign ci = AW'(col_mod);

  // --------------------------------------------------------------------------
  // Column-state memory: read at accept, written back as stage 1 advances
  // --------------------------------------------------------------------------
  ent_t          col_mem [MAX_COLS];
  ent_t          mem_rd_q;
  ent_t          col_new;
  logic [AW-1:0] s1_addr_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mem_rd_q <= col_mem[ci];
    end
    if (s1_adv) begin
      col_mem[s1_addr_q] <= col_new;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1 registers and forwarding
  // --------------------------------------------------------------------------
  logic [LW-1:0]   s1_pix_q;
  logic [PosW-1:0] s1_col_q;
  logic [PosW-1:0] s1_row_q;
  logic            fwd_q;
  ent_t            fwd_data_q;

  // A pixel read the same entry that the previous pixel writes back at the
  // same edge: the memory returns the stale word, so take the written one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= s1_adv && (s1_addr_q == ci);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pix_q   <= pix_i.data.label[LW-1:0];
      s1_col_q   <= pix_i.data.col;
      s1_row_q   <= pix_i.data.row;
      s1_addr_q  <= ci;
      fwd_data_q <= col_new;
    end
  end

  // --------------------------------------------------------------------------
  // Row state and the per-axis compute
  // --------------------------------------------------------------------------
  ent_t  row_q;
  ent_t  row_cur;
  ent_t  col_cur;
  axis_t h_res;
  axis_t v_res;

  always_comb begin
    // column zero restarts the row, row zero restarts the column entry
    row_cur = (s1_col_q == '0) ? '0 : row_q;
    if (s1_row_q == '0) begin
      col_cur = '0;
    end else if (fwd_q) begin
      col_cur = fwd_data_q;
    end else begin
      col_cur = mem_rd_q;
    end
    h_res   = scan_axis(row_cur, s1_pix_q, gap_limit_q, s1_col_q);
    v_res   = scan_axis(col_cur, s1_pix_q, gap_limit_q, s1_row_q);
    col_new = v_res.ent;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else if (s1_adv) begin
      row_q <= h_res.ent;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  lgfm_res_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q.out_row  <= s1_row_q;
      out_q.out_col  <= s1_col_q;
      out_q.h_fill   <= (h_res.len != '0);
      out_q.h_length <= h_res.len;
      out_q.v_fill   <= (v_res.len != '0);
      out_q.v_length <= v_res.len;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

endmodule

[tb/label_gap_fill_marker_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// label_gap_fill_marker_core_tb
// Self-checking bench for the label gap fill marker. A short table of
// directed pixels, then random raster images with noise bursts, pass through
// the block. A scoreboard with its own row and column scan state predicts
// every result, and each result transaction is compared field by field.
// ----------------------------------------------------------------------------
module label_gap_fill_marker_core_tb;
  import lgfm_pkg::*;

  // Scan state of one axis, plus the run length that a pixel produced
  typedef struct packed {
    logic [CountW-1:0] cnt;
    logic [LabelW-1:0] tag;
    logic [LenW-1:0]   len;
  } axis_t;

  // One row of the directed table; lim < 0 keeps the current gap limit
  typedef struct {
    int              lim;
    logic [LabelW-1:0] label;
    int              col;
    int              row;
    bit              no_run;
  } dir_row_t;

  localparam int NumCols  = 1024;
  localparam int RandPix  = 1800;
  localparam int IdlePct  = 29;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we;
  logic [LimitW-1:0] cfg_wdata;

  lgfm_pix_if pix ();
  lgfm_res_if res ();

  label_gap_fill_marker_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .pix_i       (pix),
    .res_o       (res)
  );

  // Scoreboard state: our own copy of the gap limit and the scan state
  logic [LimitW-1:0] gap_lim;
  logic [CountW-1:0] row_cnt;
  logic [LabelW-1:0] row_tag;
  logic [CountW-1:0] col_cnt [NumCols];
  logic [LabelW-1:0] col_tag [NumCols];
  bit                col_opened [NumCols];  // column has seen a row 0 pixel

  lgfm_res_t gap_expect_q [$];
  dir_row_t  dir_table [$];

  // The pixel being offered; no_run_now marks a table row with a typed result
  bit        no_run_now;
  bit        calm;

  int n_err;
  int n_pix;
  int n_res;
  int n_fills;
  int n_limits;

  // --------------------------------------------------------------------------
  // Clock, and a hard stop in case the block hangs
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(2_000_000);
    $display("%0t: timeout with %0d results outstanding", $time, gap_expect_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  // Advance one axis by one pixel: a nonzero pixel that differs from the last
  // label while the countdown is still live bridges the background run behind
  // it. The run never reaches below index zero.
  function automatic axis_t scan_run(axis_t s, logic [LabelW-1:0] p,
                                     logic [LimitW-1:0] lim, logic [PosW-1:0] pos);
    int unsigned c;
    int unsigned n;
    axis_t       r;
    c = s.cnt;
    n = 0;
    r = s;
    if (p != '0) begin
      if (c != 0 && p != s.tag && lim > c) n = lim - c;
      c     = lim + 1;
      r.tag = p;
    end
    if (c != 0) c = c - 1;
    r.cnt = c[CountW-1:0];
    if (n > pos) n = pos;
    r.len = n[LenW-1:0];
    return r;
  endfunction

  // Work out the result of one accepted pixel and advance the scan state
  function automatic lgfm_res_t predict_gap(lgfm_pix_t p);
    axis_t     h;
    axis_t     v;
    lgfm_res_t r;
    if (p.col == 0) begin
      row_cnt = '0;
      row_tag = '0;
    end
    if (p.row == 0) begin
      col_cnt[p.col] = '0;
      col_tag[p.col] = '0;
    end
    h = scan_run('{cnt: row_cnt, tag: row_tag, len: '0}, p.label, gap_lim, p.col);
    v = scan_run('{cnt: col_cnt[p.col], tag: col_tag[p.col], len: '0},
                 p.label, gap_lim, p.row);
    row_cnt        = h.cnt;
    row_tag        = h.tag;
    col_cnt[p.col] = v.cnt;
    col_tag[p.col] = v.tag;
    r.out_row  = p.row;
    r.out_col  = p.col;
    r.h_fill   = (h.len != 0);
    r.h_length = h.len;
    r.v_fill   = (v.len != 0);
    r.v_length = v.len;
    return r;
  endfunction

  // Never read a column entry that no row 0 pixel has opened: pull such a
  // pixel back to row 0, which opens the entry.
  function automatic lgfm_pix_t legalise_pixel(lgfm_pix_t p);
    if (p.row != 0 && !col_opened[p.col]) p.row = '0;
    col_opened[p.col] = 1'b1;
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Monitors: take pixels into the predictor, check results as they leave
  // --------------------------------------------------------------------------
  task automatic check_field(string name, int unsigned e, int unsigned a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
      n_err++;
    end
  endtask

  always @(posedge clk_i) begin
    lgfm_res_t e;
    lgfm_res_t a;
    lgfm_res_t p;
    if (rst_ni && res.valid && res.ready) begin
      a = res.data;
      if (gap_expect_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got row %0d col %0d",
                 $time, a.out_row, a.out_col);
        n_err++;
      end else begin
        e = gap_expect_q.pop_front();
        check_field("out_row",  e.out_row,  a.out_row);
        check_field("out_col",  e.out_col,  a.out_col);
        check_field("h_fill",   e.h_fill,   a.h_fill);
        check_field("h_length", e.h_length, a.h_length);
        check_field("v_fill",   e.v_fill,   a.v_fill);
        check_field("v_length", e.v_length, a.v_length);
        n_res++;
        if (e.h_fill || e.v_fill) n_fills++;
      end
    end
    if (rst_ni && pix.valid && pix.ready) begin
      p = predict_gap(pix.data);
      // Table rows with an obvious answer are held to the typed value: no run
      // in either direction, position echoed back.
      if (no_run_now) begin
        p.h_fill   = 1'b0;
        p.h_length = '0;
        p.v_fill   = 1'b0;
        p.v_length = '0;
        p.out_row  = pix.data.row;
        p.out_col  = pix.data.col;
      end
      gap_expect_q.push_back(p);
      n_pix++;
    end
  end

  // Result side back-pressure; drop ready about 29 times in a hundred
  always @(negedge clk_i) begin
    res.ready <= calm || ($urandom_range(0, 99) >= IdlePct);
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers; every task is entered and left at a falling edge
  // --------------------------------------------------------------------------
  // Offer one pixel, with random gaps before it, and hold until it is taken
  task automatic drive_pixel(lgfm_pix_t p, bit no_run);
    while (!calm && $urandom_range(0, 99) < IdlePct) begin
      pix.valid = 1'b0;
      @(negedge clk_i);
    end
    pix.valid  = 1'b1;
    pix.data   = p;
    no_run_now = no_run;
    do @(posedge clk_i); while (!pix.ready);
    @(negedge clk_i);
  endtask

  // Hold the pixel side until every outstanding result has been checked
  task automatic settle_block();
    pix.valid = 1'b0;
    while (gap_expect_q.size() != 0) @(negedge clk_i);
  endtask

  // Write the gap limit with the block idle
  task automatic load_limit(logic [LimitW-1:0] v);
    settle_block();
    repeat (3) @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk_i);
    cfg_we    = 1'b0;
    gap_lim   = v;
    n_limits++;
  endtask

  task automatic add_row(int lim, logic [LabelW-1:0] label, int col, int row, bit no_run);
    dir_row_t d;
    d.lim    = lim;
    d.label  = label;
    d.col    = col;
    d.row    = row;
    d.no_run = no_run;
    dir_table.push_back(d);
  endtask

  function automatic logic [LabelW-1:0] any_label();
    logic [LabelW-1:0] l;
    l = LabelW'($urandom);
    while (l == '0) l = LabelW'($urandom);
    return l;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    lgfm_pix_t         p;
    dir_row_t          d;
    logic [LabelW-1:0] palette [3];
    int                w;
    int                h;
    int                c0;
    int                row_now;
    int                zero_pct;
    int                n_rand;

    // Drive every input to a known value from time zero
    rst_ni     = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    pix.valid  = 1'b0;
    pix.data   = '0;
    res.ready  = 1'b0;
    no_run_now = 1'b0;
    calm       = 1'b0;
    gap_lim    = GapLimitRst;
    row_cnt    = '0;
    row_tag    = '0;
    n_err      = 0;
    n_pix      = 0;
    n_res      = 0;
    n_fills    = 0;
    n_limits   = 0;
    for (int i = 0; i < NumCols; i++) begin
      col_cnt[i]    = '0;
      col_tag[i]    = '0;
      col_opened[i] = 1'b0;
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table, gap limit at its reset value of 4 to begin with
    add_row(-1, 16'd5,    0,    0,    1);  // first pixel after reset
    add_row(-1, 16'h8000, 1,    0,    1);  // differing labels adjacent
    add_row(-1, 16'd0,    2,    0,    1);  // background never ends a run
    add_row(-1, 16'd0,    3,    0,    1);
    add_row(-1, 16'h7fff, 4,    0,    0);  // bridges the two zeros behind it
    add_row(-1, 16'h7fff, 5,    0,    0);  // same label, no run
    add_row(-1, 16'd1,    1023, 0,    0);  // last column opened
    add_row(-1, 16'd0,    0,    1,    0);  // row restart
    add_row(-1, 16'd0,    1,    1,    0);
    add_row(-1, 16'd9,    0,    2,    0);  // vertical run in column 0
    add_row(-1, 16'hffff, 1023, 1023, 0);  // last row, last column
    add_row(0,  16'd3,    0,    0,    1);  // limit 0 never bridges
    add_row(-1, 16'd0,    1,    0,    1);
    add_row(-1, 16'd4,    2,    0,    1);
    add_row(4,  16'd1,    0,    3,    0);
    add_row(255, 16'd2,   1,    3,    0);  // limit raised mid row: clip at col
    add_row(-1, 16'd0,    2,    3,    0);
    add_row(-1, 16'd0,    3,    3,    0);
    add_row(-1, 16'd7,    4,    3,    0);
    add_row(-1, 16'd1,    0,    4,    0);
    add_row(8,  16'd2,    1,    4,    0);  // limit lowered: countdown too high
    add_row(-1, 16'd0,    2,    4,    0);
    add_row(-1, 16'd3,    3,    4,    0);

    foreach (dir_table[i]) begin
      d = dir_table[i];
      if (d.lim >= 0) load_limit(d.lim[LimitW-1:0]);
      p.label = d.label;
      p.col   = d.col[PosW-1:0];
      p.row   = d.row[PosW-1:0];
      drive_pixel(legalise_pixel(p), d.no_run);
    end
    no_run_now = 1'b0;

    // Random part: mostly raster images with a few labels and runs of
    // background, now and then a burst of noise pixels
    n_rand = 0;
    while (n_rand < RandPix) begin
      // Leave a long stretch with both sides running flat out
      calm = (n_rand >= 600 && n_rand < 900);

      if (!calm && $urandom_range(0, 99) < 30) begin
        case ($urandom_range(0, 5))
          0:       load_limit('0);
          1:       load_limit(8'd255);
          2:       load_limit(GapLimitRst);
          default: load_limit(LimitW'($urandom_range(1, 254)));
        endcase
      end else if (!calm && $urandom_range(0, 99) < 4) begin
        settle_block();
      end

      if ($urandom_range(0, 9) == 0) begin
        // Noise: any label, any position within the contract
        repeat (20) begin
          p.label = LabelW'($urandom);
          p.col   = PosW'($urandom_range(0, NumCols - 1));
          p.row   = PosW'($urandom_range(0, 1023));
          drive_pixel(legalise_pixel(p), 0);
          n_rand++;
        end
      end else begin
        if ($urandom_range(0, 9) == 0) begin
          // Wide, sparse image so long runs under a large limit appear
          w        = $urandom_range(100, 300);
          h        = $urandom_range(1, 2);
          zero_pct = 95;
        end else begin
          w        = $urandom_range(1, 20);
          h        = $urandom_range(1, 12);
          zero_pct = $urandom_range(30, 90);
        end
        c0      = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, NumCols - w);
        row_now = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 1023) : 0;
        for (int k = 0; k < 3; k++) palette[k] = any_label();
        if ($urandom_range(0, 7) == 0) palette[0] = 16'h8000;
        if ($urandom_range(0, 7) == 0) palette[1] = 16'h7fff;
        for (int r = 0; r < h && n_rand < RandPix; r++) begin
          for (int c = 0; c < w && n_rand < RandPix; c++) begin
            p.label = ($urandom_range(0, 99) < zero_pct) ? '0 : palette[$urandom_range(0, 2)];
            p.col   = PosW'(c0 + c);
            p.row   = PosW'(row_now);
            drive_pixel(legalise_pixel(p), 0);
            n_rand++;
          end
          // Advance to the next row; sometimes skip ahead to a distant row
          if ($urandom_range(0, 9) == 0 || row_now >= 1023) row_now = $urandom_range(1, 1023);
          else row_now = row_now + 1;
        end
      end
    end
    calm = 1'b0;

    // Drain, then allow the pipeline a few more edges for stray results
    settle_block();
    repeat (8) @(posedge clk_i);

    $display("Run covered %0d pixels, %0d results checked, %0d with a marked run,",
             n_pix, n_res, n_fills);
    $display("under %0d gap limit writes, with %0d mismatches.", n_limits, n_err);
    if (n_err == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
